>>> rtl/fpln_pkg.sv
// Shared types, constants and stage functions for the fixed-point natural log block.
`timescale 1ns / 1ps

package fpln_pkg;

  localparam int FRAC_BITS   = 11;
  localparam int IN_W        = 16;
  localparam int LOG_W       = 15;
  localparam int MANT_W      = 12;
  localparam int LEN_W       = 5;
  localparam int STAGES      = 12;
  localparam int STAGE_IDX_W = 4;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [LOG_W-1:0]  LN2      = 15'd1420;
  localparam logic [MANT_W-1:0] MANT_ONE = 12'd2048;
  localparam logic [MANT_W-1:0] MANT_MIN = 12'd1024;

  typedef struct packed {
    logic [LOG_W-1:0]  y;
    logic [MANT_W-1:0] m;
    logic              zero;
  } item_t;

  function automatic logic [LOG_W-1:0] stage_log(input logic [STAGE_IDX_W-1:0] idx);
    logic [LOG_W-1:0] c;
    c = '0;
    unique case (idx)
      4'd1:    c = 15'd830;
      4'd2:    c = 15'd457;
      4'd3:    c = 15'd241;
      4'd4:    c = 15'd124;
      4'd5:    c = 15'd63;
      4'd6:    c = 15'd32;
      4'd7:    c = 15'd16;
      4'd8:    c = 15'd8;
      4'd9:    c = 15'd4;
      4'd10:   c = 15'd2;
      4'd11:   c = 15'd1;
      default: c = '0;
    endcase
    return c;
  endfunction

  // times-2 step: only an exact 1024 mantissa can double without passing one
  function automatic item_t pow_step(input item_t it);
    item_t r;
    r = it;
    if (!it.zero && it.m == MANT_MIN) begin
      r.m = MANT_ONE;
      r.y = it.y - LN2;
    end
    return r;
  endfunction

  // multiply by (1 + 2^-idx) when the product stays at or below one
  function automatic item_t k_step(input item_t it, input logic [STAGE_IDX_W-1:0] idx);
    item_t r;
    logic [MANT_W:0] cand;
    r    = it;
    cand = {1'b0, it.m} + ({1'b0, it.m} >> idx);
    if (!it.zero && cand <= {1'b0, MANT_ONE}) begin
      r.m = cand[MANT_W-1:0];
      r.y = it.y - stage_log(idx);
    end
    return r;
  endfunction

endpackage

>>> rtl/fpln_front.sv
// Front end: accept operands, find bit length, seed the estimate and normalize the mantissa.
`timescale 1ns / 1ps

module fpln_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [fpln_pkg::IN_W-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output fpln_pkg::item_t          out_item
);

  logic                             valid;
  fpln_pkg::item_t                  item;
  fpln_pkg::item_t                  item_next;
  logic [fpln_pkg::LEN_W-1:0]       len;
  logic [fpln_pkg::IN_W+fpln_pkg::FRAC_BITS-1:0] scaled;
  logic [fpln_pkg::LOG_W-1:0]                    seed;

  always_comb begin
    len = '0;
    for (int i = 0; i < fpln_pkg::IN_W; i++) begin
      if (in_value[i]) len = fpln_pkg::LEN_W'(i + 1);
    end
    scaled = {in_value, {fpln_pkg::FRAC_BITS{1'b0}}} >> len;
    seed   = fpln_pkg::LOG_W'(len) * fpln_pkg::LN2;
    item_next.zero = (in_value == '0);
    item_next.m    = scaled[fpln_pkg::MANT_W-1:0];
    item_next.y    = item_next.zero ? '0 : seed;
  end

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= item_next;
    end
  end

endmodule

>>> rtl/fpln_queue.sv
// Short request queue between front and back ends.
`timescale 1ns / 1ps

module fpln_queue #(
  parameter int DEPTH = fpln_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  fpln_pkg::item_t push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output fpln_pkg::item_t pop_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  fpln_pkg::item_t  mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

>>> rtl/fpln_back.sv
// Back end: twelve registered shift-add-compare stages ending in the output register.
`timescale 1ns / 1ps

module fpln_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  fpln_pkg::item_t in_item,
  output logic            out_valid,
  input  logic            out_ready,
  output fpln_pkg::item_t out_item
);

  localparam int LAST = fpln_pkg::STAGES - 1;

  logic            st_valid [fpln_pkg::STAGES];
  fpln_pkg::item_t st_item  [fpln_pkg::STAGES];
  logic            adv;

  assign adv       = !st_valid[LAST] || out_ready;
  assign in_ready  = adv;
  assign out_valid = st_valid[LAST];
  assign out_item  = st_item[LAST];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < fpln_pkg::STAGES; i++) st_valid[i] <= 1'b0;
    end else if (adv) begin
      st_valid[0] <= in_valid;
      for (int i = 1; i < fpln_pkg::STAGES; i++) st_valid[i] <= st_valid[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_item[0] <= fpln_pkg::pow_step(in_item);
      for (int i = 1; i < fpln_pkg::STAGES; i++) begin
        st_item[i] <= fpln_pkg::k_step(st_item[i-1], fpln_pkg::STAGE_IDX_W'(i));
      end
    end
  end

endmodule

>>> rtl/fixed_point_natural_log.sv
// Top level of the fixed-point natural log block: front end, queue and stage pipeline.
//
//  channel | dir | fields (tdata / tuser, lowest bit first)
//  s_*     | in  | tdata[15:0] value
//  m_*     | out | tdata[14:0] log_value, tdata[15] zero; tuser[0] zero_operand
//
// One request per cycle sustained while the output side does not stall; a request passes
// the front register, a queue entry and the twelve back-end stage registers in turn.
// The back end advances as a whole whenever its output register is empty or taken.
// Reset (rst, synchronous) clears all valid flags and queue pointers.
// The queue absorbs front-end results while the output side stalls.
`timescale 1ns / 1ps

module fixed_point_natural_log #(
  parameter int QUEUE_DEPTH = fpln_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] value
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [14:0] log_value, [15] zero fill
  output logic        m_tuser    // [0] zero_operand
);

  logic            fr_valid;
  logic            fr_ready;
  fpln_pkg::item_t fr_item;
  logic            q_valid;
  logic            q_ready;
  fpln_pkg::item_t q_item;
  fpln_pkg::item_t res_item;

  fpln_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_value  (s_tdata),
    .out_valid (fr_valid),
    .out_ready (fr_ready),
    .out_item  (fr_item)
  );

  fpln_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_item  (fr_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  fpln_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_valid),
    .in_ready  (q_ready),
    .in_item   (q_item),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_item  (res_item)
  );

  assign m_tdata = {1'b0, res_item.y};
  assign m_tuser = res_item.zero;

endmodule

>>> test/fpln_result_checker.sv
// Checker for the natural log block: predicts each result from the accepted requests and compares.
`timescale 1ns / 1ps

module fpln_result_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] value
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,   // [14:0] log_value, [15] zero fill
  input  logic        m_tuser,   // [0] zero_operand
  output int          mismatches,
  output int          outstanding
);

  typedef struct packed {
    logic [fpln_pkg::LOG_W-1:0] log_value;
    logic                       zero_operand;
  } log_result_t;

  log_result_t expected_logs[$];
  log_result_t oldest;

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  function automatic logic [15:0] ln_term(input int stage);
    logic [15:0] c;
    case (stage)
      0:       c = 16'd7098;
      1:       c = 16'd5678;
      2:       c = 16'd4259;
      3:       c = 16'd2839;
      4:       c = 16'd1420;
      5:       c = 16'd830;
      6:       c = 16'd457;
      7:       c = 16'd241;
      8:       c = 16'd124;
      9:       c = 16'd63;
      10:      c = 16'd32;
      11:      c = 16'd16;
      12:      c = 16'd8;
      13:      c = 16'd4;
      14:      c = 16'd2;
      default: c = 16'd1;
    endcase
    return c;
  endfunction

  function automatic log_result_t natural_log_q11(input logic [15:0] value);
    log_result_t r;
    logic [4:0]  len;
    logic [31:0] mant;
    logic [31:0] step_k;
    logic [31:0] cand;
    logic [15:0] acc;
    int          s;
    r.log_value    = '0;
    r.zero_operand = (value == 16'd0);
    if (value != 16'd0) begin
      len = 5'd0;
      for (s = 0; s < 16; s++) begin
        if (value[s]) len = 5'(s + 1);
      end
      acc  = 16'(len) * 16'd1420;
      mant = ({16'd0, value} << 11) >> len;
      for (s = 0; s < 16; s++) begin
        if (s < 5) begin
          step_k = 32'd32 >> s;
          cand   = mant * step_k;
        end else begin
          step_k = 32'd1 << (s - 4);
          cand   = mant + mant / step_k;
        end
        if (cand <= 32'd2048) begin
          mant = cand;
          acc  = acc - ln_term(s);
        end
      end
      r.log_value = acc[14:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch: %s got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) expected_logs.push_back(natural_log_q11(s_tdata));
      if (m_tvalid && m_tready) begin
        if (expected_logs.size() == 0) begin
          report_mismatch("result with no request outstanding, log_value", m_tdata[14:0], 0);
        end else begin
          oldest = expected_logs.pop_front();
          if (m_tdata[14:0] !== oldest.log_value)
            report_mismatch("log_value", m_tdata[14:0], oldest.log_value);
          if (m_tdata[15] !== 1'b0)
            report_mismatch("tdata fill bit", m_tdata[15], 0);
          if (m_tuser !== oldest.zero_operand)
            report_mismatch("zero_operand", m_tuser, oldest.zero_operand);
        end
      end
      outstanding <= expected_logs.size();
    end
  end

endmodule

>>> test/tb_fixed_point_natural_log.sv
// Testbench top for the natural log block: clock, reset, request stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_fixed_point_natural_log;

  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int DRAIN_CYCLES    = 30;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata  = 16'd0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tuser;

  int mismatches;
  int outstanding;
  int send_idle_pct  = 37;
  int recv_idle_pct  = 48;
  int hold_requests  = 0;
  int holds_done     = 0;
  int idle_cycles    = 0;
  int n;

  logic [15:0] corner_values[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  fixed_point_natural_log dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  fpln_result_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // hold off the output for a long stretch when asked, otherwise stall at random
  initial begin
    forever begin
      @(posedge clk);
      if (holds_done != hold_requests) begin
        holds_done = hold_requests;
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_value(input logic [15:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  function automatic logic [15:0] random_operand();
    logic [15:0] p;
    p = 16'd1 << $urandom_range(15);
    case ($urandom_range(9))
      0:       return p;
      1:       return $urandom_range(1) ? p - 16'd1 : p + 16'd1;
      2:       return 16'($urandom_range(15));
      3:       return 16'($urandom_range(1023, 16));
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  initial begin
    corner_values = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd7, 16'd255, 16'd256,
                      16'd1023, 16'd1024, 16'd1025, 16'd2047, 16'd4096, 16'd21845,
                      16'd43690, 16'd32767, 16'd32768, 16'd32769, 16'd65534, 16'd65535,
                      16'd0};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (corner_values[i]) send_value(corner_values[i]);
    for (n = 0; n < 400; n++) send_value(random_operand());

    send_idle_pct = 48;
    recv_idle_pct = 37;
    for (n = 0; n < 400; n++) send_value(random_operand());

    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (n = 0; n < 350; n++) begin
      if (n == 40) hold_requests <= hold_requests + 1;
      send_value(random_operand());
    end
    s_tvalid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
